// ===== rtl/psmw_pkg.sv =====
package psmw_pkg;

  localparam int ARR_W            = 32;
  localparam int SVC_W            = 32;
  localparam int RANK_W           = 10;
  localparam int IDX_W            = 10;
  localparam int TIME_W           = 40;
  localparam int WORD_W           = 32;
  localparam int COL_W            = 5;
  localparam int RANK_SPAN        = 1024;
  localparam int DEF_MAX_REQUESTS = 1024;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  typedef struct packed {
    logic [ARR_W-1:0] arr;
    logic [SVC_W-1:0] svc;
    logic [IDX_W-1:0] idx;
    logic             last;
  } req_t;

  typedef struct packed {
    logic busy;
    logic drain;
    logic map_empty;
  } status_t;

  // Index of the lowest set bit, zero when none is set.
  function automatic logic [COL_W-1:0] lowest_set(input logic [WORD_W-1:0] w);
    logic [COL_W-1:0] pos;
    pos = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (w[i]) pos = COL_W'(i);
    end
    return pos;
  endfunction

endpackage

// ===== rtl/priority_server_max_wait_core.sv =====
// channel | valid     | stall     | payload
// input   | in_valid  | in_stall  | in_arrival_time, in_service_time, in_priority_rank, in_last
// result  | out_valid | out_stall | out_max_wait
//
// A request is admitted through the idle and check states; each waiting request it starts
// passes through check, bitmap pick with data memory read, and start, and the server goes idle in check.
// A last request emits the result once the server is idle and no request is waiting.
// A 2-entry queue lets the input side take transactions while the back works.
// Synchronous active-low reset; the pending store needs no clearing pass.
// The result register holds while out_stall is high; the back waits on it.
module priority_server_max_wait_core #(
  parameter int MAX_REQUESTS = psmw_pkg::DEF_MAX_REQUESTS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [psmw_pkg::ARR_W-1:0]  in_arrival_time,
  input  logic [psmw_pkg::SVC_W-1:0]  in_service_time,
  input  logic [psmw_pkg::RANK_W-1:0] in_priority_rank,
  input  logic                        in_last,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [psmw_pkg::TIME_W-1:0] out_max_wait
);
  import psmw_pkg::*;

  logic    q_push;
  logic    q_ready;
  logic    q_pop;
  logic    q_valid;
  req_t    q_in;
  req_t    q_out;
  status_t status;

  psmw_front #(.MAX_REQUESTS(MAX_REQUESTS)) u_front (
    .in_valid         (in_valid),
    .in_arrival_time  (in_arrival_time),
    .in_service_time  (in_service_time),
    .in_priority_rank (in_priority_rank),
    .in_last          (in_last),
    .q_ready          (q_ready),
    .q_push           (q_push),
    .q_item           (q_in),
    .in_stall         (in_stall)
  );

  psmw_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_in),
    .ready (q_ready),
    .pop   (q_pop),
    .dout  (q_out),
    .valid (q_valid)
  );

  psmw_back #(.MAX_REQUESTS(MAX_REQUESTS)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_valid),
    .q_item       (q_out),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_max_wait (out_max_wait),
    .out_stall    (out_stall),
    .status       (status)
  );

  // waiting requests exist only behind a busy server
  a_wait_needs_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !status.map_empty |-> status.busy)
    else $error("pending requests with idle server");

  a_result_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(status.drain))
    else $error("result without drain");

  a_cleared_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> (!status.busy && status.map_empty && !status.drain))
    else $error("state not cleared after result");

endmodule

// ===== rtl/psmw_front.sv =====
module psmw_front #(
  parameter int MAX_REQUESTS = psmw_pkg::DEF_MAX_REQUESTS
) (
  input  logic                        in_valid,
  input  logic [psmw_pkg::ARR_W-1:0]  in_arrival_time,
  input  logic [psmw_pkg::SVC_W-1:0]  in_service_time,
  input  logic [psmw_pkg::RANK_W-1:0] in_priority_rank,
  input  logic                        in_last,
  input  logic                        q_ready,
  output logic                        q_push,
  output psmw_pkg::req_t              q_item,
  output logic                        in_stall
);
  import psmw_pkg::*;

  localparam int MOD_M    = (MAX_REQUESTS < RANK_SPAN) ? MAX_REQUESTS : RANK_SPAN;
  localparam int RECIP_SH = 20;
  localparam int RECIP    = (1 << RECIP_SH) / MOD_M;
  localparam int PROD_W   = RANK_W + RECIP_SH + 1;

  logic [PROD_W-1:0] quo_prod;
  logic [RANK_W-1:0] quo_est;
  logic [31:0]       rem_raw;
  logic [31:0]       rem_fix;

  // rank folded into the store depth: reciprocal multiply, quotient low by at most one
  assign quo_prod = PROD_W'(in_priority_rank) * PROD_W'(RECIP);
  assign quo_est  = quo_prod[RECIP_SH +: RANK_W];
  assign rem_raw  = 32'(in_priority_rank) - 32'(quo_est) * 32'(MOD_M);
  assign rem_fix  = (rem_raw >= 32'(MOD_M)) ? rem_raw - 32'(MOD_M) : rem_raw;

  assign in_stall    = !q_ready;
  assign q_push      = in_valid && q_ready;
  assign q_item.arr  = in_arrival_time;
  assign q_item.svc  = in_service_time;
  assign q_item.idx  = IDX_W'(rem_fix);
  assign q_item.last = in_last;

endmodule

// ===== rtl/psmw_fifo.sv =====
module psmw_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  psmw_pkg::req_t din,
  output logic           ready,
  input  logic           pop,
  output psmw_pkg::req_t dout,
  output logic           valid
);
  import psmw_pkg::*;

  req_t       slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;

  assign ready = (cnt_r != 2'd2);
  assign valid = (cnt_r != 2'd0);
  assign dout  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= din;
  end

endmodule

// ===== rtl/psmw_back.sv =====
module psmw_back #(
  parameter int MAX_REQUESTS = psmw_pkg::DEF_MAX_REQUESTS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  input  psmw_pkg::req_t              q_item,
  output logic                        q_pop,
  output logic                        out_valid,
  output logic [psmw_pkg::TIME_W-1:0] out_max_wait,
  input  logic                        out_stall,
  output psmw_pkg::status_t           status
);
  import psmw_pkg::*;

  localparam int DEPTH = (MAX_REQUESTS < RANK_SPAN) ? MAX_REQUESTS : RANK_SPAN;
  localparam int ROWS  = (DEPTH + WORD_W - 1) / WORD_W;
  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int DEP_W = $clog2(DEPTH);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CHECK = 4'b0010,
    S_PICK  = 4'b0100,
    S_START = 4'b1000
  } state_t;

  state_t                   state_r;
  req_t                     cur_r;
  logic                     busy_r;
  logic                     drain_r;
  logic [TIME_W-1:0]        finish_r;
  logic [TIME_W-1:0]        worst_r;
  logic [ROWS-1:0]          summary_r;
  logic [WORD_W-1:0]        bitmap_r [ROWS];
  logic [ROW_W-1:0]         row_r;
  logic [ARR_W+SVC_W-1:0]   mem [DEPTH];
  logic [ARR_W+SVC_W-1:0]   rd_r;
  logic                     out_valid_r;
  logic [TIME_W-1:0]        out_wait_r;

  logic                     retire;
  logic                     out_free;
  logic                     emit;
  logic [ROW_W-1:0]         ins_row;
  logic [COL_W-1:0]         ins_col;
  logic [ROW_W-1:0]         top_row;
  logic [WORD_W-1:0]        pick_word;
  logic [COL_W-1:0]         pick_col;
  logic [IDX_W-1:0]         pick_idx;
  logic [WORD_W-1:0]        pick_left;
  logic [TIME_W-1:0]        rd_arr;
  logic [TIME_W-1:0]        wait_val;
  logic [TIME_W:0]          fin_sum;
  logic [TIME_W-1:0]        fin_val;
  logic [TIME_W-1:0]        cur_arr;

  assign cur_arr   = TIME_W'(cur_r.arr);
  assign retire    = busy_r && (drain_r || finish_r <= cur_arr);
  assign out_free  = !out_valid_r || !out_stall;
  assign emit      = (state_r == S_CHECK) && !retire && drain_r && out_free;
  assign ins_row   = cur_r.idx[COL_W +: ROW_W];
  assign ins_col   = cur_r.idx[COL_W-1:0];
  assign top_row   = ROW_W'(lowest_set(WORD_W'(summary_r)));
  assign pick_word = bitmap_r[row_r];
  assign pick_col  = lowest_set(pick_word);
  assign pick_idx  = IDX_W'({row_r, pick_col});
  assign pick_left = pick_word & ~(WORD_W'(1) << pick_col);

  // started at the current finish time
  assign rd_arr   = TIME_W'(rd_r[ARR_W+SVC_W-1:SVC_W]);
  assign wait_val = (finish_r >= rd_arr) ? finish_r - rd_arr : '0;
  assign fin_sum  = {1'b0, finish_r} + (TIME_W+1)'(rd_r[SVC_W-1:0]);
  assign fin_val  = fin_sum[TIME_W] ? TIME_MAX : fin_sum[TIME_W-1:0];

  assign q_pop        = (state_r == S_IDLE) && q_valid;
  assign out_valid    = out_valid_r;
  assign out_max_wait = out_wait_r;

  assign status.busy      = busy_r;
  assign status.drain     = drain_r;
  assign status.map_empty = (summary_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      busy_r      <= 1'b0;
      drain_r     <= 1'b0;
      finish_r    <= '0;
      worst_r     <= '0;
      summary_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) state_r <= S_CHECK;
        end
        S_CHECK: begin
          priority if (retire) begin
            if (summary_r == '0) begin
              busy_r <= 1'b0;
            end else begin
              state_r <= S_PICK;
            end
          end else if (drain_r) begin
            if (out_free) begin
              drain_r     <= 1'b0;
              busy_r      <= 1'b0;
              finish_r    <= '0;
              worst_r     <= '0;
              summary_r   <= '0;
              state_r     <= S_IDLE;
            end
          end else begin
            if (!busy_r) begin
              busy_r   <= 1'b1;
              finish_r <= cur_arr + TIME_W'(cur_r.svc);
            end else begin
              summary_r[ins_row] <= 1'b1;
            end
            if (cur_r.last) begin
              drain_r <= 1'b1;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        S_PICK: begin
          if (pick_left == '0) summary_r[row_r] <= 1'b0;
          state_r <= S_START;
        end
        S_START: begin
          if (wait_val > worst_r) worst_r <= wait_val;
          finish_r <= fin_val;
          state_r  <= S_CHECK;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur_r <= q_item;
    if (state_r == S_CHECK && retire) row_r <= top_row;
    if (emit) out_wait_r <= worst_r;
    // a row whose summary bit is clear holds stale bits
    if (state_r == S_CHECK && !retire && !drain_r && busy_r) begin
      bitmap_r[ins_row] <= (summary_r[ins_row] ? bitmap_r[ins_row] : '0)
                           | (WORD_W'(1) << ins_col);
    end
    if (state_r == S_PICK) bitmap_r[row_r] <= pick_left;
  end

  always_ff @(posedge clk) begin
    if (state_r == S_CHECK && !retire && !drain_r && busy_r) begin
      mem[cur_r.idx[DEP_W-1:0]] <= {cur_r.arr, cur_r.svc};
    end
    if (state_r == S_PICK) rd_r <= mem[pick_idx[DEP_W-1:0]];
  end

endmodule

// ===== dv/priority_server_max_wait_core_tb.sv =====
module priority_server_max_wait_core_tb;
  import psmw_pkg::*;

  localparam int NREQ = DEF_MAX_REQUESTS;
  localparam int IDLE_LIMIT = 20000;
  localparam logic [TIME_W-1:0] TOP = TIME_MAX;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [ARR_W-1:0] in_arrival_time = '0;
  logic [SVC_W-1:0] in_service_time = '0;
  logic [RANK_W-1:0] in_priority_rank = '0;
  logic in_last = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [TIME_W-1:0] out_max_wait;

  priority_server_max_wait_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_arrival_time(in_arrival_time), .in_service_time(in_service_time),
    .in_priority_rank(in_priority_rank), .in_last(in_last),
    .out_valid(out_valid), .out_stall(out_stall), .out_max_wait(out_max_wait)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state: waiting requests by rank, server and running worst wait
  bit                waiting [NREQ];
  logic [ARR_W-1:0]  wait_arr [NREQ];
  logic [SVC_W-1:0]  wait_svc [NREQ];
  bit                busy_p;
  logic [TIME_W-1:0] fin_p;
  logic [TIME_W-1:0] worst_p;

  logic [TIME_W-1:0] expected_waits[$];
  int  errors = 0;
  int  idle_cycles = 0;
  bit  rx_hold = 1'b0;
  bit  quiet = 1'b0;
  logic [ARR_W-1:0] clock_now;

  function automatic void start_req(logic [TIME_W-1:0] now, logic [ARR_W-1:0] a,
                                    logic [SVC_W-1:0] s);
    logic [TIME_W-1:0] w;
    logic [TIME_W:0] f;
    w = (now >= TIME_W'(a)) ? now - TIME_W'(a) : '0;
    f = {1'b0, now} + (TIME_W+1)'(s);
    if (w > worst_p) worst_p = w;
    fin_p = (f > {1'b0, TOP}) ? TOP : f[TIME_W-1:0];
    busy_p = 1'b1;
  endfunction

  function automatic void retire_running();
    busy_p = 1'b0;
    for (int k = 0; k < NREQ; k++) begin
      if (waiting[k]) begin
        waiting[k] = 1'b0;
        start_req(fin_p, wait_arr[k], wait_svc[k]);
        return;
      end
    end
  endfunction

  function automatic void predict_request(logic [ARR_W-1:0] a, logic [SVC_W-1:0] s,
                                          logic [RANK_W-1:0] r, bit lst);
    int k;
    k = int'(r) % NREQ;
    while (busy_p && fin_p <= TIME_W'(a)) retire_running();
    if (!busy_p) begin
      start_req(TIME_W'(a), a, s);
    end else begin
      waiting[k] = 1'b1;
      wait_arr[k] = a;
      wait_svc[k] = s;
    end
    if (lst) begin
      while (busy_p) retire_running();
      expected_waits.push_back(worst_p);
      foreach (waiting[i]) waiting[i] = 1'b0;
      busy_p = 1'b0;
      fin_p = '0;
      worst_p = '0;
    end
  endfunction

  // leaves in_valid high; the next call or a pause takes it down
  task automatic send_request(logic [ARR_W-1:0] a, logic [SVC_W-1:0] s,
                              logic [RANK_W-1:0] r, bit lst);
    while (!quiet && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_arrival_time <= a;
    in_service_time <= s;
    in_priority_rank <= r;
    in_last <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_request(a, s, r, lst);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_waits.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // one set of n requests with unique ranks and nondecreasing arrivals unless the arrival counter wraps
  task automatic send_set(int n, int step_max, int svc_max);
    bit used [NREQ];
    int r;
    for (int i = 0; i < n; i++) begin
      do r = $urandom_range(NREQ - 1); while (used[r]);
      used[r] = 1'b1;
      clock_now = clock_now + ARR_W'($urandom_range(step_max));
      send_request(clock_now, SVC_W'($urandom_range(svc_max)), RANK_W'(r), i == n - 1);
    end
  endtask

  task automatic test_directed();
    send_request(32'd0, 32'd0, 10'd0, 1'b1);
    send_request(32'd5, 32'd10, 10'd3, 1'b0);
    send_request(32'd6, 32'd4, 10'd1, 1'b0);
    send_request(32'd7, 32'd2, 10'd2, 1'b0);
    // duplicate rank overwrites the waiting entry
    send_request(32'd8, 32'd9, 10'd2, 1'b0);
    send_request(32'd30, 32'd1, 10'd1023, 1'b1);
    // finish times beyond the 32-bit arrival range
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'd0, 1'b0);
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'd1023, 1'b0);
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'd512, 1'b1);
    // arrivals out of order
    send_request(32'd100, 32'd50, 10'd7, 1'b0);
    send_request(32'd20, 32'd5, 10'd8, 1'b0);
    send_request(32'd10, 32'd5, 10'd6, 1'b1);
    send_request(32'h5555_5555, 32'hAAAA_AAAA, 10'h155, 1'b0);
    send_request(32'hAAAA_AAAA, 32'h5555_5555, 10'h2AA, 1'b1);
    wait_drained();
  endtask

  task automatic test_random_sets();
    int sent;
    sent = 0;
    clock_now = '0;
    while (sent < 1200) begin
      int n;
      n = ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(8, 1);
      if ($urandom_range(5) == 0) clock_now = $urandom();
      case ($urandom_range(3))
        0: send_set(n, 3, 20);
        1: send_set(n, 50, 40);
        2: send_set(n, 1000, 100000);
        default: send_set(n, 32'hFFFF, 32'hFFFF_FFFF);
      endcase
      sent += n;
      if (sent > 500 && sent < 600) quiet = 1'b1;
      else quiet = 1'b0;
    end
    wait_drained();
  endtask

  task automatic test_noise();
    // fully random fields, including duplicates and disorder
    for (int i = 0; i < 350; i++)
      send_request($urandom(), $urandom(), RANK_W'($urandom()), $urandom_range(7) == 0);
    send_request($urandom(), $urandom(), RANK_W'($urandom()), 1'b1);
    wait_drained();
  endtask

  task automatic test_backpressure();
    rx_hold = 1'b1;
    fork
      begin
        repeat (400) @(negedge clk);
        rx_hold = 1'b0;
      end
      begin
        clock_now = 32'd1000;
        for (int i = 0; i < 6; i++) send_set(4, 10, 30);
        wait_drained();
      end
    join
  endtask

  // receiver stall
  always @(negedge clk) begin
    if (rx_hold) out_stall <= 1'b1;
    else if (quiet) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < 11);
  end

  // result checker and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
      if (out_valid && !out_stall) begin
        if (expected_waits.size() == 0) begin
          $display("%0t: unexpected transaction max_wait=%0d", $time, out_max_wait);
          errors++;
        end else begin
          logic [TIME_W-1:0] e;
          e = expected_waits.pop_front();
          if (out_max_wait !== e) begin
            $display("%0t: max_wait expected %0d actual %0d", $time, e, out_max_wait);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    foreach (waiting[i]) waiting[i] = 1'b0;
    busy_p = 1'b0;
    fin_p = '0;
    worst_p = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_backpressure();
    test_random_sets();
    test_noise();
    if (errors == 0 && expected_waits.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
